// ----- design/sha256_pkg.sv -----
// SHA-256 stream hasher package: round constants, initial hash words, sequencer states.
// Used by sha256_round and sha256_stream_hasher_core.
package sha256_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned PAD_LEN_POS = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [7:0] hash_t;

    localparam hash_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    typedef enum logic [2:0] {
        ST_FILL,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } seq_state_t;

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ----- design/sha256_round.sv -----
// SHA-256 round unit: one compression round and one schedule word per cycle.
// Depends on sha256_pkg.
module sha256_round
    import sha256_pkg::*;
(
    input  hash_t         work_in,
    input  word_t [15:0]  sched_in,
    input  logic  [5:0]   round_idx,
    output hash_t         work_out,
    output word_t [15:0]  sched_out
);

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    word_t wt, sg0, sg1, s0, s1, ch, maj, t1, t2;

    always_comb begin
        // window slot 0 holds w[t]; slots 1,9,14 hold w[t+1], w[t+9], w[t+14]
        sg0 = rotr(sched_in[1], 7) ^ rotr(sched_in[1], 18) ^ (sched_in[1] >> 3);
        sg1 = rotr(sched_in[14], 17) ^ rotr(sched_in[14], 19) ^ (sched_in[14] >> 10);
        wt  = sched_in[0];
        for (int i = 0; i < 15; i++) begin
            sched_out[i] = sched_in[i+1];
        end
        sched_out[15] = sg1 + sched_in[9] + sg0 + sched_in[0];

        s1  = rotr(work_in[4], 6) ^ rotr(work_in[4], 11) ^ rotr(work_in[4], 25);
        ch  = (work_in[4] & work_in[5]) ^ (~work_in[4] & work_in[6]);
        t1  = work_in[7] + s1 + ch + round_k(round_idx) + wt;
        s0  = rotr(work_in[0], 2) ^ rotr(work_in[0], 13) ^ rotr(work_in[0], 22);
        maj = (work_in[0] & work_in[1]) ^ (work_in[0] & work_in[2]) ^
              (work_in[1] & work_in[2]);
        t2  = s0 + maj;
        work_out[7] = work_in[6];
        work_out[6] = work_in[5];
        work_out[5] = work_in[4];
        work_out[4] = work_in[3] + t1;
        work_out[3] = work_in[2];
        work_out[2] = work_in[1];
        work_out[1] = work_in[0];
        work_out[0] = t1 + t2;
    end

endmodule

// ----- design/sha256_stream_hasher_core.sv -----
// SHA-256 stream hasher top level: byte intake, padding, round sequencer, digest output.
// Depends on sha256_pkg and sha256_round.
//
// Byte-serial SHA-256. Each input transaction carries one byte (tdata[7:0]),
// a has_byte flag and an end-of-message flag (tlast). Bytes are collected
// into 16 message words. When the 64th byte of a block lands, the block is
// compressed by one shared round unit: a load step, 64 rounds and an add
// step. On tlast the core pads the message (0x80, zeros, 64-bit big-endian
// bit length, one extra block when more than 55 bytes are pending), fills
// the rest of the data block and any extra block with pad bytes, runs one or two
// compressions, then presents the eight digest words, word 0 first, one per
// accepted output transaction, with m_tlast on word 7. The core then returns
// to the initial hash state. s_axis_tready is low throughout compression,
// padding and digest output. The bit count wraps modulo 2^64.
module sha256_stream_hasher_core
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);

    seq_state_t   state_reg, state_next;
    hash_t        chain_reg;
    hash_t        work_reg;
    word_t [15:0] sched_reg;
    logic [5:0]   fill_reg;     // bytes pending, also the pad write pointer
    logic [63:0]  bit_count_reg;
    logic [5:0]   round_reg;
    logic         final_reg;    // compression belongs to the padded tail
    logic         len_done_reg; // length has been placed in the tail block
    logic [2:0]   emit_reg;

    hash_t        work_rnd;
    word_t [15:0] sched_rnd;

    sha256_round u_round (
        .work_in  (work_reg),
        .sched_in (sched_reg),
        .round_idx(round_reg),
        .work_out (work_rnd),
        .sched_out(sched_rnd)
    );

    logic in_fire, out_fire;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // outputs
    always_comb begin
        s_axis_tready = (state_reg == ST_FILL);
        m_axis_tvalid = (state_reg == ST_EMIT);
        m_axis_tdata  = {5'd0, emit_reg, chain_reg[emit_reg]};
        m_axis_tlast  = (emit_reg == 3'd7);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL: begin
                if (in_fire) begin
                    if (s_axis_tuser && fill_reg == 6'd63) begin
                        state_next = ST_LOAD;
                    end else if (s_axis_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (fill_reg == 6'd63) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: begin
                if (round_reg == 6'd63) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!final_reg) begin
                    state_next = ST_FILL;
                end else if (len_done_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT: begin
                if (out_fire && emit_reg == 3'd7) begin
                    state_next = ST_FILL;
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    // write one byte into the big-endian word window
    function automatic word_t [15:0] put_byte(input word_t [15:0] s,
                                              input logic [5:0] pos,
                                              input logic [7:0] b);
        word_t [15:0] r;
        r = s;
        r[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
        return r;
    endfunction

    logic [7:0] pad_byte;
    always_comb begin
        // first pad byte after the data is 0x80; length bytes at 56..63
        if (fill_reg >= 6'(PAD_LEN_POS) && len_done_reg) begin
            pad_byte = bit_count_reg[(63 - fill_reg[2:0] * 8) -: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    logic pad_mark_reg; // 0x80 still to be written

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            chain_reg     <= INIT_HASH;
            fill_reg      <= '0;
            bit_count_reg <= '0;
            round_reg     <= '0;
            final_reg     <= 1'b0;
            len_done_reg  <= 1'b0;
            pad_mark_reg  <= 1'b0;
            emit_reg      <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_FILL: begin
                    if (in_fire) begin
                        final_reg <= s_axis_tlast;
                        if (s_axis_tuser) begin
                            sched_reg     <= put_byte(sched_reg, fill_reg, s_axis_tdata);
                            bit_count_reg <= bit_count_reg + 64'd8;
                            fill_reg      <= fill_reg + 6'd1;
                        end
                        pad_mark_reg <= s_axis_tlast;
                        // length fits if the 0x80 lands below byte 56
                        if (s_axis_tuser) begin
                            len_done_reg <= (fill_reg < 6'd55);
                        end else begin
                            len_done_reg <= (fill_reg < 6'd56);
                        end
                    end
                end
                ST_PAD: begin
                    if (pad_mark_reg) begin
                        sched_reg    <= put_byte(sched_reg, fill_reg, PAD_BYTE);
                        pad_mark_reg <= 1'b0;
                    end else begin
                        sched_reg <= put_byte(sched_reg, fill_reg, pad_byte);
                    end
                    fill_reg <= fill_reg + 6'd1;
                end
                ST_LOAD: begin
                    work_reg  <= chain_reg;
                    round_reg <= '0;
                end
                ST_ROUND: begin
                    work_reg  <= work_rnd;
                    sched_reg <= sched_rnd;
                    round_reg <= round_reg + 6'd1;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                    fill_reg <= '0;
                    // a tail block without room for the length still needs its extra pad block
                    if (final_reg && !len_done_reg) begin
                        len_done_reg <= 1'b1;
                    end
                    emit_reg <= '0;
                end
                ST_EMIT: begin
                    if (out_fire) begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7) begin
                            chain_reg     <= INIT_HASH;
                            bit_count_reg <= '0;
                            fill_reg      <= '0;
                            final_reg     <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- tb/sha256_stream_hasher_core_tb.sv -----
// Testbench for sha256_stream_hasher_core: drives byte messages, checks digest words.
// Depends on sha256_pkg for the initial words, round constants and pad byte.
`timescale 1ns / 1ps

class digest_scoreboard;
    logic [31:0] want_word[$];
    logic [2:0]  want_index[$];
    logic        want_last[$];
    logic [31:0] chain[8];
    logic [7:0]  block_bytes[64];
    int unsigned fill;
    logic [63:0] bits;
    int unsigned mismatches;
    int unsigned digests_seen;
    int unsigned words_checked;

    function new();
        restart();
        mismatches = 0;
        digests_seen = 0;
        words_checked = 0;
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::INIT_HASH[i];
        fill = 0;
        bits = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
        logic [31:0] w[16];
        logic [31:0] v[8];
        logic [31:0] wt, t1, t2, a15, a2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                wt = w[i];
            end else begin
                a15 = w[(i-15) & 15];
                a2 = w[(i-2) & 15];
                wt = (rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10)) + w[(i-7) & 15]
                     + (rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3)) + w[i & 15];
                w[i & 15] = wt;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::round_k(i[5:0]) + wt;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--) v[j] = v[j-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    // Note one accepted input transaction and queue any digest it completes.
    function void note_input(logic [7:0] data, logic has_byte, logic is_last);
        int unsigned pos;
        if (has_byte) begin
            block_bytes[fill] = data;
            bits = bits + 64'd8;
            fill++;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        end
        if (!is_last) return;
        pos = fill;
        block_bytes[pos++] = sha256_pkg::PAD_BYTE;
        if (pos > 56) begin
            while (pos < 64) block_bytes[pos++] = 8'h00;
            compress();
            pos = 0;
        end
        while (pos < 56) block_bytes[pos++] = 8'h00;
        for (int i = 0; i < 8; i++) block_bytes[56+i] = bits[63-8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++) begin
            want_word.push_back(chain[i]);
            want_index.push_back(i[2:0]);
            want_last.push_back(i == 7);
        end
        digests_seen++;
        restart();
    endfunction

    // Check one accepted output transaction against the oldest expectation.
    function void check_word(logic [39:0] data, logic tlast);
        logic [31:0] ew;
        logic [2:0]  ei;
        logic        el;
        words_checked++;
        if (want_word.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected digest word %h idx %0d", data[31:0], data[34:32]);
            return;
        end
        ew = want_word.pop_front();
        ei = want_index.pop_front();
        el = want_last.pop_front();
        if (data[31:0] !== ew || data[34:32] !== ei || tlast !== el) begin
            mismatches++;
            if (mismatches <= 10)
                $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                         ew, ei, el, data[31:0], data[34:32], tlast);
        end
    endfunction
endclass

module sha256_stream_hasher_core_tb;
    import sha256_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    digest_scoreboard digests = new();
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    bit          calm_mode = 1'b0;   // no idling on either side while set

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    sha256_stream_hasher_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // Sample both channels at the rising edge; score accepted transactions.
    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                digests.note_input(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                digests.check_word(m_axis_tdata, m_axis_tlast);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Stall the digest output at random, except during the calm stretch.
    always @(negedge aclk) begin
        if (!aresetn) m_axis_tready <= 1'b0;
        else m_axis_tready <= calm_mode || ($urandom_range(99) >= 10);
    end

    // Present one transaction and hold it until accepted; idle gaps come first.
    // Return at the falling edge after acceptance with tvalid still high.
    task automatic send_item(logic [7:0] data, logic has_byte, logic is_last);
        while (!calm_mode && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= has_byte;
        s_axis_tlast <= is_last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (has_byte) bytes_sent++;
        @(negedge aclk);
    endtask

    // Send a whole message of random bytes; the last may carry no byte.
    task automatic send_message(int unsigned len, bit empty_tail, bit noise);
        for (int unsigned i = 0; i < len; i++) begin
            if (noise && $urandom_range(9) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            if (i + 1 == len && !empty_tail) send_item(8'($urandom_range(255)), 1'b1, 1'b1);
            else send_item(8'($urandom_range(255)), 1'b1, 1'b0);
        end
        if (empty_tail || len == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    initial begin
        int unsigned len;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty message, extreme bytes, a no-byte item mid-message.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h55, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'h7f, 1'b0, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hfe, 1'b0, 1'b1);

        // Padding boundaries: 55 fits one block, 56 and 63 spill, 64 fills one.
        send_message(55, 1'b0, 1'b0);
        send_message(56, 1'b0, 1'b0);
        send_message(63, 1'b1, 1'b0);
        send_message(64, 1'b0, 1'b0);
        send_message(64, 1'b1, 1'b0);

        // Random messages, with a calm stretch in the middle.
        while (bytes_sent < 400) begin
            calm_mode = (bytes_sent > 320 && bytes_sent < 370);
            len = ($urandom_range(3) == 0) ? $urandom_range(70) : $urandom_range(12);
            send_message(len, 1'($urandom_range(1)), 1'b1);
        end
        s_axis_tvalid <= 1'b0;
        calm_mode = 1'b0;

        while (digests.want_word.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("hashed %0d messages from %0d bytes, %0d digest words checked",
                 digests.digests_seen, bytes_sent, digests.words_checked);
        $display("mismatches: %0d", digests.mismatches);
        if (digests.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
